### rtl/core/iale_pkg.sv
package iale_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = 16;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] FILL_WORD = {WORD_W{1'b1}};

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_CAP   = 2'd2;

  // RAM write selection
  localparam logic [2:0] WR_NONE     = 3'd0;
  localparam logic [2:0] WR_VAL_IDX  = 3'd1;
  localparam logic [2:0] WR_FILL_IDX = 3'd2;
  localparam logic [2:0] WR_FILL_PTR = 3'd3;
  localparam logic [2:0] WR_MOVE_PTR = 3'd4;

  // RAM read address selection
  localparam logic [1:0] RA_IDX  = 2'd0;
  localparam logic [1:0] RA_IDX1 = 2'd1;
  localparam logic [1:0] RA_PTR2 = 2'd2;

  typedef struct packed {
    logic       ld_in;
    logic [2:0] wr_sel;
    logic [1:0] ra_sel;
    logic       ptr_ld_cnt;
    logic       ptr_ld_idx;
    logic       ptr_inc;
    logic       cnt_set_idx;
    logic       cnt_dec;
    logic       cap_rd;
    logic       st_ld;
    logic [1:0] st_code;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_lt_cnt;
    logic       idx_ge_depth;
    logic       cnt_one;
    logic       idx_last;
    logic       fill_last;
    logic       move_last;
    logic       out_free;
  } sts_t;

endpackage

### rtl/core/iale_ram.sv
module iale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/iale_ctrl.sv
module iale_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  iale_pkg::sts_t sts,
  output iale_pkg::cmd_t cmd
);
  import iale_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_GETW = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_DONE;
        case (sts.op)
          OP_PUT: begin
            if (sts.idx_lt_cnt) begin
              cmd.wr_sel = WR_VAL_IDX;
            end else if (sts.idx_ge_depth) begin
              cmd.st_ld   = 1'b1;
              cmd.st_code = ST_CAP;
            end else begin
              cmd.ptr_ld_cnt = 1'b1;
              state_nxt      = S_FILL;
            end
          end
          OP_GET: begin
            if (sts.idx_lt_cnt) begin
              cmd.ra_sel = RA_IDX;
              state_nxt  = S_GETW;
            end else begin
              cmd.st_ld   = 1'b1;
              cmd.st_code = ST_RANGE;
            end
          end
          OP_REMOVE: begin
            if (!sts.idx_lt_cnt) begin
              cmd.st_ld   = 1'b1;
              cmd.st_code = ST_RANGE;
            end else if (sts.cnt_one) begin
              cmd.wr_sel = WR_FILL_IDX;
            end else if (sts.idx_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              // prime the read of the entry above the hole
              cmd.ra_sel     = RA_IDX1;
              cmd.ptr_ld_idx = 1'b1;
              state_nxt      = S_MOVE;
            end
          end
          default: begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = ST_RANGE;
          end
        endcase
      end
      S_FILL: begin
        if (sts.fill_last) begin
          cmd.wr_sel      = WR_VAL_IDX;
          cmd.cnt_set_idx = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.wr_sel  = WR_FILL_PTR;
          cmd.ptr_inc = 1'b1;
        end
      end
      S_GETW: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_MOVE: begin
        // write the word read last cycle, fetch the next one
        cmd.wr_sel  = WR_MOVE_PTR;
        cmd.ra_sel  = RA_PTR2;
        cmd.ptr_inc = 1'b1;
        if (sts.move_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/iale_dp.sv
module iale_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_op,
  input  logic [iale_pkg::IDX_W-1:0]        in_index,
  input  logic signed [iale_pkg::WORD_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [iale_pkg::WORD_W-1:0] out_read_value,
  output logic [iale_pkg::CNT_W-1:0]        out_length,
  output logic [1:0]                        out_status,
  input  iale_pkg::cmd_t                    cmd,
  output iale_pkg::sts_t                    sts
);
  import iale_pkg::*;

  logic [1:0]        op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [WORD_W-1:0] rd_r;
  logic [1:0]        st_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_rd_r;
  logic [CNT_W-1:0]  out_len_r;
  logic [1:0]        out_st_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  iale_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[ADDR_W-1:0];
    ram_wdata = val_r;
    case (cmd.wr_sel)
      WR_VAL_IDX: begin
        ram_we = 1'b1;
      end
      WR_FILL_IDX: begin
        ram_we    = 1'b1;
        ram_wdata = FILL_WORD;
      end
      WR_FILL_PTR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = FILL_WORD;
      end
      WR_MOVE_PTR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.ra_sel)
      RA_IDX1: ram_raddr = idx_r[ADDR_W-1:0] + ADDR_W'(1);
      RA_PTR2: ram_raddr = ptr_r + ADDR_W'(2);
      default: ram_raddr = idx_r[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_set_idx) begin
      cnt_nxt = CNT_W'(idx_r[ADDR_W-1:0]) + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_ld_cnt) begin
      ptr_nxt = cnt_r[ADDR_W-1:0];
    end else if (cmd.ptr_ld_idx) begin
      ptr_nxt = idx_r[ADDR_W-1:0];
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.ld_in) begin
      op_r  <= in_op;
      idx_r <= in_index;
      val_r <= in_value;
      rd_r  <= FILL_WORD;
      st_r  <= ST_OK;
    end else begin
      if (cmd.cap_rd) begin
        rd_r <= ram_rdata;
      end
      if (cmd.st_ld) begin
        st_r <= cmd.st_code;
      end
    end
    if (cmd.emit) begin
      out_rd_r  <= rd_r;
      out_len_r <= cnt_r;
      out_st_r  <= st_r;
    end
  end

  assign sts.op           = op_r;
  assign sts.idx_lt_cnt   = {{(IDX_W-CNT_W){1'b0}}, cnt_r} > idx_r;
  assign sts.idx_ge_depth = {1'b0, idx_r} >= (IDX_W+1)'(DEPTH);
  assign sts.cnt_one      = (cnt_r == CNT_W'(1));
  assign sts.idx_last     = {{(IDX_W+1-CNT_W){1'b0}}, cnt_r} == ({1'b0, idx_r} + (IDX_W+1)'(1));
  assign sts.fill_last    = (ptr_r == idx_r[ADDR_W-1:0]);
  assign sts.move_last    = ((CNT_W'(ptr_r) + CNT_W'(2)) == cnt_r);
  assign sts.out_free     = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_length     = out_len_r;
  assign out_status     = out_st_r;

endmodule

### rtl/core/indexed_array_list_engine.sv
// Growable list of signed 32-bit words held in a 1024-entry single-port-write RAM.
// Input channel (in_valid/in_stall): op (put, get, remove), index and value.
// Result channel (out_valid/out_stall): read_value, length after the op, status.
// One result beat per accepted input beat, in order.
// Items are worked one at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// A put past the length writes the fill word into the gap, one gap fill write
// per cycle, then writes the value; a remove that shifts moves the entries above
// the index down, one read-ahead/write-behind move per cycle.
// The result register is freed when taken, so a new item is accepted while a
// result still waits; if the receiver stalls, the next result holds in its final
// state until the register frees.
// Reset (rst_n low, synchronous) empties the list; RAM contents are not cleared
// and entries are only read after being written.
module indexed_array_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [15:0]        in_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic [10:0]        out_length,
  output logic [1:0]         out_status
);
  import iale_pkg::*;

  cmd_t cmd;
  sts_t sts;

  iale_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  iale_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_index      (in_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .out_length    (out_length),
    .out_status    (out_status),
    .cmd           (cmd),
    .sts           (sts)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item was in flight");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length <= CNT_W'(DEPTH)))
    else $error("length beyond capacity");

  a_err_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_read_value == FILL_WORD))
    else $error("error result carries a read value");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over a stalled beat");
`endif

endmodule

### sim/tb_indexed_array_list_engine.sv
`timescale 1ns / 1ps

module tb_indexed_array_list_engine;
  import iale_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int WAIT_MAX   = 13;
  localparam int IDLE_LIMIT = 6000;
  localparam int RANDOM_OPS = 580;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] index;
    logic [31:0] value;
  } list_cmd_t;

  typedef struct {
    logic [31:0] read_value;
    logic [10:0] length;
    logic [1:0]  status;
  } list_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = '0;
  logic [15:0]        in_index = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_read_value;
  logic [10:0]        out_length;
  logic [1:0]         out_status;

  list_cmd_t   cmds_pending[$];
  list_reply_t replies_due[$];

  // shadow of the list kept by the predictor
  logic [31:0] shadow_words [DEPTH];
  int unsigned shadow_len = 0;

  // length as seen while the command list is being built
  int unsigned plan_len = 0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  bit   in_burst = 1'b0;
  bit   out_burst = 1'b0;
  int   in_hold = 0;
  int   out_hold = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   peak_len = 0;
  int   op_count [4] = '{0, 0, 0, 0};

  indexed_array_list_engine DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .out_status     (out_status)
  );

  always #6 clk = ~clk;

  function automatic list_reply_t apply_list_op(input list_cmd_t c);
    list_reply_t r;
    int unsigned pos;
    r.read_value = FILL_WORD;
    r.status     = ST_OK;
    case (c.op)
      OP_PUT: begin
        if (c.index < shadow_len) begin
          shadow_words[c.index] = c.value;
        end else if (c.index >= DEPTH) begin
          r.status = ST_CAP;
        end else begin
          // pad the gap with the fill word, then append
          for (pos = shadow_len; pos < c.index; pos++) shadow_words[pos] = FILL_WORD;
          shadow_words[c.index] = c.value;
          shadow_len = c.index + 1;
        end
      end
      OP_GET: begin
        if (c.index < shadow_len) r.read_value = shadow_words[c.index];
        else r.status = ST_RANGE;
      end
      OP_REMOVE: begin
        if (c.index >= shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len == 1) begin
          // the only entry is blanked, the length holds
          shadow_words[c.index] = FILL_WORD;
        end else begin
          for (pos = c.index; pos + 1 < shadow_len; pos++)
            shadow_words[pos] = shadow_words[pos + 1];
          shadow_len--;
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.length = 11'(shadow_len);
    return r;
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : int'($urandom_range(0, WAIT_MAX));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  task automatic queue_cmd(input logic [1:0] op, input int unsigned idx,
                           input logic [31:0] val);
    list_cmd_t c;
    c.op    = op;
    c.index = 16'(idx);
    c.value = val;
    cmds_pending.insert(cmds_pending.size(), c);
    if (op == OP_PUT && idx >= plan_len && idx < DEPTH) plan_len = idx + 1;
    else if (op == OP_REMOVE && idx < plan_len && plan_len > 1) plan_len--;
  endtask

  // input side: present queued beats, hold while stalled
  always @(negedge clk) begin : in_drive
    list_cmd_t c;
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_hold > 0) begin
        in_hold--;
        in_valid <= 1'b0;
      end else if (cmds_pending.size() != 0) begin
        c = cmds_pending.pop_front();
        in_valid <= 1'b1;
        in_op    <= c.op;
        in_index <= c.index;
        in_value <= c.value;
        if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
        in_hold = draw_wait(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: stall for a drawn number of cycles after every beat taken
  always @(negedge clk) begin : out_pace
    if (out_fire) begin
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      out_hold = draw_wait(out_burst);
    end
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    list_cmd_t   c;
    list_reply_t want;
    in_fire  <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding", results_seen));
      end else begin
        want = replies_due.pop_front();
        if (out_read_value !== want.read_value)
          report_mismatch($sformatf("result %0d read_value got %h want %h",
                                    results_seen, out_read_value, want.read_value));
        if (out_length !== want.length)
          report_mismatch($sformatf("result %0d length got %0d want %0d",
                                    results_seen, out_length, want.length));
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    results_seen, out_status, want.status));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      c.op    = in_op;
      c.index = in_index;
      c.value = in_value;
      replies_due.insert(replies_due.size(), apply_list_op(c));
      op_count[in_op]++;
      if (shadow_len > peak_len) peak_len = shadow_len;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned sel;
    int unsigned idx;
    logic [1:0]  op;

    // empty list, unknown op, lone entry, gap fill, shifts, capacity
    queue_cmd(OP_GET, 0, 32'h1234_5678);
    queue_cmd(OP_REMOVE, 0, 32'h0);
    queue_cmd(OP_UNKNOWN, 16'hFFFF, 32'h0);
    queue_cmd(OP_PUT, 0, 32'h7FFF_FFFF);
    queue_cmd(OP_REMOVE, 0, 32'h0);
    queue_cmd(OP_GET, 0, 32'h0);
    queue_cmd(OP_PUT, 0, 32'h8000_0000);
    queue_cmd(OP_PUT, 5, 32'h0);
    queue_cmd(OP_GET, 3, 32'hFFFF_FFFF);
    queue_cmd(OP_GET, 5, 32'h0);
    queue_cmd(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_PUT, DEPTH, 32'd123);
    queue_cmd(OP_GET, 16'hFFFF, 32'h0);
    queue_cmd(OP_REMOVE, 2, 32'h0);
    queue_cmd(OP_GET, 2, 32'h0);
    queue_cmd(OP_REMOVE, 4, 32'h0);
    queue_cmd(OP_REMOVE, 16'h8000, 32'h0);
    queue_cmd(OP_UNKNOWN, 0, 32'h5555_AAAA);
    queue_cmd(OP_PUT, 4, 32'hA5A5_5A5A);
    queue_cmd(OP_GET, 4, 32'h0);
    queue_cmd(OP_GET, 0, 32'h0);

    repeat (RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      if (pick < 3) begin
        op  = OP_UNKNOWN;
        idx = $urandom_range(0, 65535);
      end else if (pick < ((plan_len > 160) ? 30 : 48)) begin
        op = OP_PUT;
        if (plan_len != 0 && sel < 11) idx = $urandom_range(0, plan_len - 1);
        else if (sel < 17) idx = plan_len + $urandom_range(0, 6);
        else if (sel < 18) idx = plan_len + $urandom_range(0, 100);
        else idx = $urandom_range(DEPTH, 65535);
      end else begin
        op = (pick < 75) ? OP_GET : OP_REMOVE;
        if (plan_len != 0 && sel < 15) idx = $urandom_range(0, plan_len - 1);
        else if (sel < 18) idx = plan_len + $urandom_range(0, 3);
        else idx = $urandom_range(0, 65535);
      end
      queue_cmd(op, idx, $urandom);
    end

    // finish with the list driven to full capacity
    queue_cmd(OP_PUT, DEPTH - 1, $urandom);
    queue_cmd(OP_GET, DEPTH - 1, 32'h0);
    queue_cmd(OP_GET, DEPTH, 32'h0);
    queue_cmd(OP_PUT, DEPTH, $urandom);
    queue_cmd(OP_PUT, 0, $urandom);
    queue_cmd(OP_REMOVE, DEPTH - 1, 32'h0);
    queue_cmd(OP_PUT, DEPTH - 1, $urandom);
    queue_cmd(OP_GET, DEPTH / 2, 32'h0);

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (!(cmds_pending.size() == 0 && !in_valid && replies_due.size() == 0)
           && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles < IDLE_LIMIT) repeat (12) @(posedge clk);

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, replies_due.size());
      $display("RESULT: ERROR");
    end else begin
      $display("Ran %0d puts, %0d gets, %0d removes and %0d unknown ops; peak length %0d.",
               op_count[OP_PUT], op_count[OP_GET], op_count[OP_REMOVE],
               op_count[OP_UNKNOWN], peak_len);
      $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
    end
    $finish;
  end

endmodule

### files.f
rtl/core/iale_pkg.sv
rtl/core/iale_ram.sv
rtl/core/iale_ctrl.sv
rtl/core/iale_dp.sv
rtl/core/indexed_array_list_engine.sv
sim/tb_indexed_array_list_engine.sv
